/* design/conv_pkg.sv */
// Shared types, constants and helper functions of the 3x3 convolution block.
`timescale 1ns / 1ps
`default_nettype none
package conv_pkg;

    localparam int MAX_HEIGHT  = 32;
    localparam int MAX_WIDTH   = 32;
    localparam int MAX_IN_CH   = 4;
    localparam int MAX_OUT_CH  = 4;
    localparam int NUM_WEIGHTS = 9 * MAX_IN_CH * MAX_OUT_CH;
    localparam int WGT_DEPTH   = 9 * MAX_IN_CH;
    localparam int ROW_DEPTH   = 3 * MAX_WIDTH * MAX_IN_CH;
    localparam int BURST       = MAX_WIDTH + 2;

    typedef enum logic [1:0] {
        OP_WEIGHT  = 2'd0,
        OP_BIAS    = 2'd1,
        OP_PIXEL   = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_HEIGHT = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_IN_CH  = 2'd2,
        CFG_OUT_CH = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_MAC,
        ST_DRAIN,
        ST_ADV,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic mac_init;
        logic mac_step;
        logic adv;
        logic push;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic pix_done;
        logic div_last;
        logic more;
        logic mac_last;
        logic busy;
        logic out_free;
    } sts_t;

    function automatic logic [5:0] clamp_dim(input logic [5:0] v);
        logic [5:0] r;
        if (v == 6'd0) begin
            r = 6'd1;
        end else if (v > 6'(MAX_WIDTH)) begin
            r = 6'(MAX_WIDTH);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [2:0] clamp_ch(input logic [2:0] v);
        logic [2:0] r;
        if (v == 3'd0) begin
            r = 3'd1;
        end else if (v > 3'(MAX_IN_CH)) begin
            r = 3'(MAX_IN_CH);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [1:0] mod3_small(input logic [2:0] v);
        logic [1:0] r;
        case (v)
            3'd0, 3'd3, 3'd6: r = 2'd0;
            3'd1, 3'd4, 3'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    // Since 2 is -1 modulo 3, the odd bits count twice.
    function automatic logic [1:0] row_mod3(input logic [4:0] v);
        logic [2:0] s;
        s = 3'(v[0]) + 3'(v[2]) + 3'(v[4]) + {1'b0, v[1], 1'b0} + {1'b0, v[3], 1'b0};
        return mod3_small(s);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [39:0] v);
        logic [31:0] r;
        if (v > 40'sh007FFFFFFF) begin
            r = 32'h7FFFFFFF;
        end else if (v < -40'sh0080000000) begin
            r = 32'h80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/conv_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module conv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

/* design/conv_dp.sv */
// Datapath: configuration, stores, frame counters, divider, MAC lanes and output register.
`timescale 1ns / 1ps
`default_nettype none
module conv_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [5:0]          cfg_wdata,
    input  wire logic [1:0]          s_tuser,
    input  wire logic [23:0]         s_tdata,
    input  wire logic                m_tready,
    output logic                     m_tvalid,
    output logic [143:0]             m_tdata,
    output logic                     m_tlast,
    input  wire conv_pkg::cmd_t      cmd,
    output conv_pkg::sts_t           sts
);

    logic [5:0] height_reg, width_reg;
    logic [2:0] in_ch_reg, out_ch_reg;
    logic [5:0] h, w;
    logic [2:0] ic, oc;

    logic [4:0]  cur_row_reg, cur_col_reg;
    logic [1:0]  cur_chan_reg, row_m3_reg;
    logic [10:0] pos_reg;
    logic [9:0]  q_reg;
    logic        fe_reg;
    logic [5:0]  n_reg;

    logic [10:0] div_q_reg;
    logic [5:0]  div_r_reg;
    logic [3:0]  div_cnt_reg;
    logic [6:0]  div_t;
    logic        div_ge;
    logic [5:0]  div_r_next;
    logic [10:0] div_q_next;

    logic [4:0]  orow_reg, ocol_reg, erow_reg, ecol_reg;
    logic [1:0]  ky_reg, kx_reg, ich_reg;
    logic        v1_reg, v2_reg;

    logic [15:0]        bias_reg [conv_pkg::MAX_OUT_CH];
    logic signed [31:0] prod_reg [conv_pkg::MAX_OUT_CH];
    logic signed [39:0] acc_reg  [conv_pkg::MAX_OUT_CH];
    logic [15:0]        wgt_dout [conv_pkg::MAX_OUT_CH];
    logic [15:0]        row_dout;

    logic [1:0]  op;
    logic [7:0]  slot;
    logic [15:0] sample;
    logic        last_col, frame_end;
    logic [11:0] total, need;
    logic [5:0]  nr, nc;
    logic        row_ok, col_ok, use_tap;
    logic [1:0]  rm;
    logic [4:0]  cc;
    logic [3:0]  tap;
    logic [8:0]  row_waddr, row_raddr;
    logic [5:0]  wgt_raddr;
    logic        row_we;

    assign h  = conv_pkg::clamp_dim(height_reg);
    assign w  = conv_pkg::clamp_dim(width_reg);
    assign ic = conv_pkg::clamp_ch(in_ch_reg);
    assign oc = conv_pkg::clamp_ch(out_ch_reg);

    assign op     = s_tuser;
    assign slot   = s_tdata[7:0];
    assign sample = s_tdata[23:8];

    assign sts.pix_done = (op == conv_pkg::OP_PIXEL) && ((3'(cur_chan_reg) + 3'd1) >= ic);
    assign last_col  = (6'(cur_col_reg) + 6'd1) >= w;
    assign frame_end = last_col && ((6'(cur_row_reg) + 6'd1) >= h);

    assign total = 12'(h) * 12'(w);
    assign nr = ((6'(orow_reg) + 6'd1) < h) ? 6'(orow_reg) + 6'd1 : h - 6'd1;
    assign nc = ((6'(ocol_reg) + 6'd1) < w) ? 6'(ocol_reg) + 6'd1 : w - 6'd1;
    assign need = 12'(nr) * 12'(w) + 12'(nc);
    assign sts.more = (n_reg < 6'(conv_pkg::BURST)) && (12'(pos_reg) < total)
                      && (need <= 12'(q_reg));

    assign div_t      = {div_r_reg, div_q_reg[10]};
    assign div_ge     = div_t >= 7'(w);
    assign div_r_next = div_ge ? 6'(div_t - 7'(w)) : div_t[5:0];
    assign div_q_next = {div_q_reg[9:0], div_ge};
    assign sts.div_last = (div_cnt_reg == 4'd10);

    assign row_ok = (ky_reg == 2'd0) ? (orow_reg != 5'd0) :
                    (ky_reg == 2'd2) ? ((6'(orow_reg) + 6'd1) < h) : 1'b1;
    assign col_ok = (kx_reg == 2'd0) ? (ocol_reg != 5'd0) :
                    (kx_reg == 2'd2) ? ((6'(ocol_reg) + 6'd1) < w) : 1'b1;
    assign use_tap = row_ok && col_ok;
    assign rm  = conv_pkg::mod3_small(3'(conv_pkg::row_mod3(orow_reg)) + 3'(ky_reg) + 3'd2);
    assign cc  = ocol_reg + 5'(kx_reg) - 5'd1;
    assign tap = {ky_reg, 1'b0} + 4'(ky_reg) + 4'(kx_reg);
    assign row_raddr = {rm, cc, ich_reg};
    assign wgt_raddr = {tap, ich_reg};
    assign sts.mac_last = (ky_reg == 2'd2) && (kx_reg == 2'd2)
                          && (3'(ich_reg) == ic - 3'd1);
    assign sts.busy = v1_reg || v2_reg;
    assign sts.out_free = !m_tvalid || m_tready;

    assign row_waddr = {row_m3_reg, cur_col_reg, cur_chan_reg};
    assign row_we    = cmd.accept && (op == conv_pkg::OP_PIXEL);

    conv_ram #(.WIDTH(16), .DEPTH(conv_pkg::ROW_DEPTH)) u_row_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (sample),
        .raddr (row_raddr),
        .rdata (row_dout)
    );

    for (genvar k = 0; k < conv_pkg::MAX_OUT_CH; k++) begin : g_lane
        logic wgt_we;
        assign wgt_we = cmd.accept && (op == conv_pkg::OP_WEIGHT)
                        && (slot < 8'(conv_pkg::NUM_WEIGHTS)) && (slot[1:0] == 2'(k));
        conv_ram #(.WIDTH(16), .DEPTH(conv_pkg::WGT_DEPTH)) u_wgt_ram (
            .aclk  (aclk),
            .we    (wgt_we),
            .waddr (slot[7:2]),
            .wdata (sample),
            .raddr (wgt_raddr),
            .rdata (wgt_dout[k])
        );

        always_ff @(posedge aclk) begin
            if (cmd.accept && (op == conv_pkg::OP_BIAS) && (slot == 8'(k))) begin
                bias_reg[k] <= sample;
            end
            prod_reg[k] <= $signed(row_dout) * $signed(wgt_dout[k]);
            if (cmd.mac_init) begin
                acc_reg[k] <= {{16{bias_reg[k][15]}}, bias_reg[k], 8'd0};
            end else if (v2_reg) begin
                acc_reg[k] <= acc_reg[k] + {{8{prod_reg[k][31]}}, prod_reg[k]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_tdata[4:0]     <= erow_reg;
            m_tdata[9:5]     <= ecol_reg;
            for (int k = 0; k < conv_pkg::MAX_OUT_CH; k++) begin
                m_tdata[10 + 32*k +: 32] <= (3'(k) < oc) ? conv_pkg::sat32(acc_reg[k]) : 32'd0;
            end
            m_tdata[143:138] <= 6'd0;
            m_tlast          <= !sts.more;
        end
        if (cmd.accept && sts.pix_done) begin
            q_reg     <= 10'(12'(cur_row_reg) * 12'(w) + 12'(cur_col_reg));
            fe_reg    <= frame_end;
            n_reg     <= 6'd0;
            div_q_reg <= pos_reg;
            div_r_reg <= 6'd0;
        end
        if (cmd.div_step) begin
            div_q_reg <= div_q_next;
            div_r_reg <= div_r_next;
            if (sts.div_last) begin
                orow_reg <= div_q_next[4:0];
                ocol_reg <= div_r_next[4:0];
            end
        end
        if (cmd.mac_init) begin
            ky_reg  <= 2'd0;
            kx_reg  <= 2'd0;
            ich_reg <= 2'd0;
        end else if (cmd.mac_step) begin
            if (3'(ich_reg) + 3'd1 < ic) begin
                ich_reg <= ich_reg + 2'd1;
            end else begin
                ich_reg <= 2'd0;
                if (kx_reg == 2'd2) begin
                    kx_reg <= 2'd0;
                    ky_reg <= ky_reg + 2'd1;
                end else begin
                    kx_reg <= kx_reg + 2'd1;
                end
            end
        end
        if (cmd.adv) begin
            erow_reg <= orow_reg;
            ecol_reg <= ocol_reg;
            n_reg    <= n_reg + 6'd1;
            if ((6'(ocol_reg) + 6'd1) >= w) begin
                ocol_reg <= 5'd0;
                orow_reg <= orow_reg + 5'd1;
            end else begin
                ocol_reg <= ocol_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg   <= 6'd32;
            width_reg    <= 6'd32;
            in_ch_reg    <= 3'd4;
            out_ch_reg   <= 3'd4;
            cur_row_reg  <= 5'd0;
            cur_col_reg  <= 5'd0;
            cur_chan_reg <= 2'd0;
            row_m3_reg   <= 2'd0;
            pos_reg      <= 11'd0;
            div_cnt_reg  <= 4'd0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    conv_pkg::CFG_HEIGHT: height_reg <= cfg_wdata;
                    conv_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata;
                    conv_pkg::CFG_IN_CH:  in_ch_reg  <= cfg_wdata[2:0];
                    conv_pkg::CFG_OUT_CH: out_ch_reg <= cfg_wdata[2:0];
                    default: ;
                endcase
            end
            if (cmd.accept && (op == conv_pkg::OP_RESTART)) begin
                cur_row_reg  <= 5'd0;
                cur_col_reg  <= 5'd0;
                cur_chan_reg <= 2'd0;
                row_m3_reg   <= 2'd0;
                pos_reg      <= 11'd0;
            end else if (row_we) begin
                if (sts.pix_done) begin
                    cur_chan_reg <= 2'd0;
                    if (frame_end) begin
                        cur_row_reg <= 5'd0;
                        cur_col_reg <= 5'd0;
                        row_m3_reg  <= 2'd0;
                    end else if (last_col) begin
                        cur_col_reg <= 5'd0;
                        cur_row_reg <= cur_row_reg + 5'd1;
                        row_m3_reg  <= (row_m3_reg == 2'd2) ? 2'd0 : row_m3_reg + 2'd1;
                    end else begin
                        cur_col_reg <= cur_col_reg + 5'd1;
                    end
                end else begin
                    cur_chan_reg <= cur_chan_reg + 2'd1;
                end
            end
            if (cmd.accept && sts.pix_done) begin
                div_cnt_reg <= 4'd0;
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            if (cmd.adv) begin
                pos_reg <= pos_reg + 11'd1;
            end else if (cmd.finish && fe_reg) begin
                pos_reg <= 11'd0;
            end
            v1_reg <= cmd.mac_step && use_tap;
            v2_reg <= v1_reg;
            if (cmd.push) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

/* design/conv_ctrl.sv */
// Controller state machine that sequences item intake, division, MAC passes and output.
`timescale 1ns / 1ps
`default_nettype none
module conv_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire conv_pkg::sts_t sts,
    output conv_pkg::cmd_t      cmd
);

    conv_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= conv_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            conv_pkg::ST_IDLE: begin
                if (s_tvalid && sts.pix_done) state_next = conv_pkg::ST_DIV;
            end
            conv_pkg::ST_DIV: begin
                if (sts.div_last) state_next = conv_pkg::ST_CHECK;
            end
            conv_pkg::ST_CHECK: begin
                state_next = sts.more ? conv_pkg::ST_MAC : conv_pkg::ST_IDLE;
            end
            conv_pkg::ST_MAC: begin
                if (sts.mac_last) state_next = conv_pkg::ST_DRAIN;
            end
            conv_pkg::ST_DRAIN: begin
                if (!sts.busy) state_next = conv_pkg::ST_ADV;
            end
            conv_pkg::ST_ADV: begin
                state_next = conv_pkg::ST_PUSH;
            end
            conv_pkg::ST_PUSH: begin
                if (sts.out_free) begin
                    state_next = sts.more ? conv_pkg::ST_MAC : conv_pkg::ST_IDLE;
                end
            end
            default: state_next = conv_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            conv_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            conv_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            conv_pkg::ST_CHECK: begin
                cmd.mac_init = sts.more;
                cmd.finish   = !sts.more;
            end
            conv_pkg::ST_MAC: begin
                cmd.mac_step = 1'b1;
            end
            conv_pkg::ST_ADV: begin
                cmd.adv = 1'b1;
            end
            conv_pkg::ST_PUSH: begin
                cmd.push     = sts.out_free;
                cmd.mac_init = sts.out_free && sts.more;
                cmd.finish   = sts.out_free && !sts.more;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

/* design/conv2d_3x3_same_stream.sv */
// Top level of the streaming 3x3 same-padded multi-channel convolution.
//
// Input items arrive on the s_ channel: tuser carries the operation (load weight,
// load bias, pixel element, restart), tdata the slot and the Q8.8 sample.
// Weights and biases are loaded first; pixel elements then stream in raster order.
// Each output pixel leaves on the m_ channel with its row, column and four Q16.16
// channels; tlast marks the last result caused by one input item.
// Load, restart and non-final pixel elements are taken without leaving the idle state. An
// element that completes a pixel passes intake, an 11-step position divider and a
// check, then for every released output pixel the shared four-lane MAC loop over
// the nine taps and all input channels, a pipeline drain and the hand-off; this
// loop sets the rate.
// One finished result waits in the output register while the next pixel is
// computed; if the receiver stalls longer, the MAC loop waits before the handoff.
// Reset clears the frame counters and sets the registers to 32x32 pixels with four
// input and four output channels; weight, bias and line-buffer contents are
// undefined until written. The user must write configuration through cfg_we, cfg_index
// and cfg_wdata only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module conv2d_3x3_same_stream (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [5:0]   cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,   // slot, sample
    input  wire logic [1:0]   s_tuser,   // operation
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [143:0]      m_tdata,   // out_row, out_col, chan0, chan1, chan2, chan3
    output logic              m_tlast
);

    conv_pkg::cmd_t cmd;
    conv_pkg::sts_t sts;

    conv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    conv_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
`default_nettype wire
